@@ rtl/sxf_pkg.sv @@
// ----------------------------------------------------------------------------
// sxf_pkg
// Shared types and constants for the sync/length/xor frame parser.
// ----------------------------------------------------------------------------
package sxf_pkg;

  localparam logic [7:0] SYNC_FIRST          = 8'h41;
  localparam logic [7:0] SYNC_SECOND         = 8'h56;
  localparam logic [7:0] AMPLITUDE_TYPE_RESET = 8'd1;
  localparam int unsigned MIN_AMP_LENGTH      = 2;

  typedef enum logic [2:0] {
    ST_HUNT_A,
    ST_HUNT_V,
    ST_TYPE,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_PAYLOAD,
    ST_CHECK
  } parse_state_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD      = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  msg_type;
    logic [15:0] frame_length;
    logic [15:0] amplitude;
    logic        amplitude_valid;
  } result_t;

endpackage

@@ rtl/sxf_in_reg.sv @@
// ----------------------------------------------------------------------------
// sxf_in_reg
// Input register for received bytes; holds one item until the parser takes it.
// ----------------------------------------------------------------------------
module sxf_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       byte_valid,
  output logic [7:0] byte_q,
  input  logic       take
);

  logic load;

  // full and not being drained this cycle
  assign in_stall = byte_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      byte_valid <= load || (byte_valid && !take);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_q <= rx_byte;
    end
  end

endmodule

@@ rtl/sxf_parser.sv @@
// ----------------------------------------------------------------------------
// sxf_parser
// Frame state machine: sync hunt, header, payload, checksum verdict.
// ----------------------------------------------------------------------------
module sxf_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [7:0]       cfg_data,
  input  logic             byte_valid,
  input  logic [7:0]       byte_q,
  output logic             take,
  input  logic             res_ready,
  output logic             res_load,
  output sxf_pkg::result_t res
);

  sxf_pkg::parse_state_t state, state_next;
  logic [7:0]  amplitude_type;
  logic [7:0]  frame_type, frame_type_next;
  logic [7:0]  length_low, length_low_next;
  logic [15:0] expected_length, expected_length_next;
  logic [15:0] received_count, received_count_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] first_two_payload, first_two_payload_next;
  logic        produces;
  logic        good;
  logic        amp_ok;
  logic [15:0] count_inc;

  assign produces = (state == sxf_pkg::ST_PAYLOAD) || (state == sxf_pkg::ST_CHECK);
  // header bytes never need the result register
  assign take     = byte_valid && (!produces || res_ready);
  assign res_load = take && produces;

  assign count_inc = received_count + 16'd1;
  assign good      = (byte_q == running_xor);
  assign amp_ok    = good && (frame_type == amplitude_type) &&
                     (expected_length >= 16'(sxf_pkg::MIN_AMP_LENGTH));

  always_comb begin
    state_next             = state;
    frame_type_next        = frame_type;
    length_low_next        = length_low;
    expected_length_next   = expected_length;
    received_count_next    = received_count;
    running_xor_next       = running_xor;
    first_two_payload_next = first_two_payload;
    res.kind               = sxf_pkg::KIND_PAYLOAD;
    res.data               = 8'd0;
    res.msg_type           = frame_type;
    res.frame_length       = expected_length;
    res.amplitude          = 16'd0;
    res.amplitude_valid    = 1'b0;
    case (state)
      sxf_pkg::ST_HUNT_A: begin
        if (byte_q == sxf_pkg::SYNC_FIRST) begin
          state_next = sxf_pkg::ST_HUNT_V;
        end
      end
      sxf_pkg::ST_HUNT_V: begin
        state_next = (byte_q == sxf_pkg::SYNC_SECOND) ? sxf_pkg::ST_TYPE
                                                      : sxf_pkg::ST_HUNT_A;
      end
      sxf_pkg::ST_TYPE: begin
        frame_type_next  = byte_q;
        running_xor_next = byte_q;
        state_next       = sxf_pkg::ST_LEN_LO;
      end
      sxf_pkg::ST_LEN_LO: begin
        length_low_next  = byte_q;
        running_xor_next = running_xor ^ byte_q;
        state_next       = sxf_pkg::ST_LEN_HI;
      end
      sxf_pkg::ST_LEN_HI: begin
        expected_length_next   = {byte_q, length_low};
        running_xor_next       = running_xor ^ byte_q;
        received_count_next    = 16'd0;
        first_two_payload_next = 16'd0;
        // zero length goes straight to the checksum
        state_next = ({byte_q, length_low} != 16'd0) ? sxf_pkg::ST_PAYLOAD
                                                     : sxf_pkg::ST_CHECK;
      end
      sxf_pkg::ST_PAYLOAD: begin
        if (received_count == 16'd0) begin
          first_two_payload_next = {first_two_payload[15:8], byte_q};
        end else if (received_count == 16'd1) begin
          first_two_payload_next = {byte_q, first_two_payload[7:0]};
        end
        running_xor_next    = running_xor ^ byte_q;
        received_count_next = count_inc;
        if (count_inc == expected_length) begin
          state_next = sxf_pkg::ST_CHECK;
        end
        res.kind = sxf_pkg::KIND_PAYLOAD;
        res.data = byte_q;
      end
      sxf_pkg::ST_CHECK: begin
        state_next          = sxf_pkg::ST_HUNT_A;
        res.kind            = good ? sxf_pkg::KIND_GOOD : sxf_pkg::KIND_BAD;
        res.amplitude       = amp_ok ? first_two_payload : 16'd0;
        res.amplitude_valid = amp_ok;
      end
      default: begin
        state_next = sxf_pkg::ST_HUNT_A;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= sxf_pkg::ST_HUNT_A;
      amplitude_type    <= sxf_pkg::AMPLITUDE_TYPE_RESET;
      frame_type        <= 8'd0;
      length_low        <= 8'd0;
      expected_length   <= 16'd0;
      received_count    <= 16'd0;
      running_xor       <= 8'd0;
      first_two_payload <= 16'd0;
    end else begin
      if (cfg_write) begin
        amplitude_type <= cfg_data;
      end
      if (take) begin
        state             <= state_next;
        frame_type        <= frame_type_next;
        length_low        <= length_low_next;
        expected_length   <= expected_length_next;
        received_count    <= received_count_next;
        running_xor       <= running_xor_next;
        first_two_payload <= first_two_payload_next;
      end
    end
  end

endmodule

@@ rtl/sxf_out_reg.sv @@
// ----------------------------------------------------------------------------
// sxf_out_reg
// Result register; holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module sxf_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_load,
  input  sxf_pkg::result_t res,
  output logic             res_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output sxf_pkg::result_t out_q
);

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_q <= res;
    end
  end

endmodule

@@ rtl/sync_length_xor_frame_parser.sv @@
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser
// Byte-stream frame parser: 'A','V' sync, type, 16-bit length, payload, xor.
// ----------------------------------------------------------------------------
// One received byte per item, one item per cycle sustained while in_stall
// stays low. A byte passes the input register, the frame state machine and
// the result register, so its result item reaches the output after it has
// been registered in both. Payload bytes and the checksum byte each give one
// result item; sync, type and length bytes give none. Input stalls only when
// a byte that gives a result meets a full, stalled result register.
// amplitude_type (reset 1) is written through cfg_write/cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
module sync_length_xor_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data,
  output logic [7:0]  msg_type,
  output logic [15:0] frame_length,
  output logic [15:0] amplitude,
  output logic        amplitude_valid
);

  logic             byte_valid;
  logic [7:0]       byte_q;
  logic             take;
  logic             res_ready;
  logic             res_load;
  sxf_pkg::result_t res;
  sxf_pkg::result_t out_q;

  sxf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .byte_valid (byte_valid),
    .byte_q     (byte_q),
    .take       (take)
  );

  sxf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_q     (byte_q),
    .take       (take),
    .res_ready  (res_ready),
    .res_load   (res_load),
    .res        (res)
  );

  sxf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_q     (out_q)
  );

  assign kind            = out_q.kind;
  assign data            = out_q.data;
  assign msg_type        = out_q.msg_type;
  assign frame_length    = out_q.frame_length;
  assign amplitude       = out_q.amplitude;
  assign amplitude_valid = out_q.amplitude_valid;

endmodule
